// ----- hw/rtl/rv64_exu_pkg.sv -----
`default_nettype none
package rv64_exu_pkg;

   typedef struct packed {
      logic        action;
      logic [31:0] instr_word;
      logic [63:0] instr_pc;
      logic [63:0] load_data;
   } req_type;

   typedef struct packed {
      logic [63:0] next_pc;
      logic [1:0]  mem_op;
      logic [63:0] mem_address;
      logic [3:0]  mem_bytes;
      logic [63:0] store_value;
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [63:0] reg_value;
      logic [1:0]  status;
      logic [63:0] halt_value;
   } rsp_type;

   localparam logic [1:0] MEM_NONE   = 2'd0;
   localparam logic [1:0] MEM_RD_REQ = 2'd1;
   localparam logic [1:0] MEM_WR_REQ = 2'd2;

   localparam logic [1:0] ST_NORMAL  = 2'd0;
   localparam logic [1:0] ST_EBREAK  = 2'd1;
   localparam logic [1:0] ST_ECALL   = 2'd2;
   localparam logic [1:0] ST_UNKNOWN = 2'd3;

   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OPIMMW = 7'h1b;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OPW    = 7'h3b;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
   localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;

   // multi-cycle operation kinds
   localparam logic [2:0] MD_MUL   = 3'd0;
   localparam logic [2:0] MD_MULH  = 3'd1;
   localparam logic [2:0] MD_MULHSU = 3'd2;
   localparam logic [2:0] MD_MULHU = 3'd3;
   localparam logic [2:0] MD_DIV   = 3'd4;
   localparam logic [2:0] MD_DIVU  = 3'd5;
   localparam logic [2:0] MD_REM   = 3'd6;
   localparam logic [2:0] MD_REMU  = 3'd7;

   typedef struct packed {
      logic [2:0] op;
      logic       word;
   } md_cmd_type;

endpackage
`default_nettype wire

// ----- hw/rtl/rv64_exu_ram.sv -----
`default_nettype none
module rv64_exu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/rv64_exu_muldiv.sv -----
`default_nettype none
// shift-add multiplier and restoring divider, one bit per cycle
module rv64_exu_muldiv (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire rv64_exu_pkg::md_cmd_type cmd,
   input  wire logic [63:0]             a,
   input  wire logic [63:0]             b,
   output logic                         done,
   output logic [63:0]                  result
);
   import rv64_exu_pkg::*;

   logic         busy_ff, busy_in;
   logic [6:0]   cnt_ff, cnt_in;
   md_cmd_type   cmd_ff, cmd_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  mc_ff, mc_in;
   logic         neg_ff, neg_in;
   logic         bz_ff, bz_in;
   logic [63:0]  a_ff, a_in;
   logic [63:0]  ua, ub, am, bm;
   logic         sa, sb, is_div;
   logic [64:0]  trial;
   logic [64:0]  madd;
   logic [127:0] fin;
   logic [63:0]  q, r, pick;

   always_comb begin
      is_div = cmd.op[2];
      am = cmd.word ? {{32{a[31] & ~(cmd.op == MD_DIVU || cmd.op == MD_REMU)}}, a[31:0]} : a;
      bm = cmd.word ? {{32{b[31] & ~(cmd.op == MD_DIVU || cmd.op == MD_REMU)}}, b[31:0]} : b;
      sa = am[63] & (cmd.op == MD_MULH || cmd.op == MD_MULHSU ||
                     cmd.op == MD_DIV || cmd.op == MD_REM);
      sb = bm[63] & (cmd.op == MD_MULH || cmd.op == MD_DIV || cmd.op == MD_REM);
      ua = sa ? 64'd0 - am : am;
      ub = sb ? 64'd0 - bm : bm;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      cmd_in  = cmd_ff;
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      neg_in  = neg_ff;
      bz_in   = bz_ff;
      a_in    = a_ff;
      done    = 1'b0;
      trial   = '0;
      madd    = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd0;
         cmd_in  = cmd;
         acc_in  = {64'd0, ua};
         mc_in   = ub;
         a_in    = am;
         bz_in   = (bm == 64'd0);
         neg_in  = is_div ? ((cmd.op == MD_REM || cmd.op == MD_REMU) ? sa : (sa ^ sb))
                          : (sa ^ sb);
      end else if (busy_ff) begin
         if (cnt_ff == 7'd64) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end else begin
            cnt_in = cnt_ff + 7'd1;
            if (cmd_ff.op[2]) begin
               // remainder high, quotient low
               trial = {acc_ff[127:63]} - {1'b0, mc_ff};
               if (!trial[64]) begin
                  acc_in = {trial[63:0], acc_ff[62:0], 1'b1};
               end else begin
                  acc_in = {acc_ff[126:0], 1'b0};
               end
            end else begin
               madd = {1'b0, acc_ff[127:64]} + (acc_ff[0] ? {1'b0, mc_ff} : 65'd0);
               acc_in = {madd, acc_ff[63:1]};
            end
         end
      end
   end

   always_comb begin
      fin  = neg_ff ? 128'd0 - acc_ff : acc_ff;
      q    = neg_ff ? 64'd0 - acc_ff[63:0] : acc_ff[63:0];
      r    = neg_ff ? 64'd0 - acc_ff[127:64] : acc_ff[127:64];
      unique case (cmd_ff.op)
         MD_MUL:                       pick = fin[63:0];
         MD_MULH, MD_MULHSU, MD_MULHU: pick = fin[127:64];
         MD_DIV, MD_DIVU:              pick = bz_ff ? '1 : q;
         default:                      pick = bz_ff ? a_ff : r;
      endcase
      result = cmd_ff.word ? {{32{pick[31]}}, pick[31:0]} : pick;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      cmd_ff <= cmd_in;
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      neg_ff <= neg_in;
      bz_ff  <= bz_in;
      a_ff   <= a_in;
   end
endmodule
`default_nettype wire

// ----- hw/rtl/rv64im_execute_unit.sv -----
`default_nettype none
// RV64IM execute unit with a private 32 x 64 register file (x0 reads zero).
// An ordinary item gives its result after rs1, rs2
// and a0 are read in turn through the single read port of the register RAM
// and the item executes; multiply and divide items then pass through the
// shared shift-add/restoring unit. A load-return item gives its result in the
// cycle after it is taken. The result sits in an output register; the next
// item is taken in the cycle after the result has been delivered, so items
// do not overlap.
module rv64im_execute_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire rv64_exu_pkg::req_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rv64_exu_pkg::rsp_type      rsp_data
);
   import rv64_exu_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD1  = 3'd1;
   localparam logic [2:0] S_RD2  = 3'd2;
   localparam logic [2:0] S_EXE  = 3'd3;
   localparam logic [2:0] S_MD   = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]  state_ff, state_in;
   req_type     req_ff;
   logic [63:0] a_ff, b_ff;
   rsp_type     out_ff, out_in;
   rsp_type     ld_rsp, md_rsp;
   logic        pl_valid_ff, pl_valid_in;
   logic [4:0]  pl_dest_ff, pl_dest_in;
   logic [1:0]  pl_size_ff, pl_size_in;
   logic        pl_signed_ff, pl_signed_in;
   logic [31:0] zero_ff;

   logic        rf_we;
   logic [4:0]  rf_wa, rf_ra;
   logic [63:0] rf_wd, rf_rd;

   logic        md_start, md_done;
   md_cmd_type  md_cmd;
   logic [63:0] md_result;

   logic [31:0] w;
   logic [6:0]  opc, f7;
   logic [2:0]  f3;
   logic [4:0]  rd;
   logic [63:0] immi, imms, immb, immj, immu, pc4, av, bv, v, tgt;
   logic        wr, unk, tkn, is_md, lz;
   logic [5:0]  sh;
   logic [63:0] a32, lv, lmask;
   logic [63:0] op2;

   rv64_exu_ram #(.WIDTH(64), .DEPTH(32)) u_rf (
      .clock(clock), .wr_en(rf_we), .wr_addr(rf_wa), .wr_data(rf_wd),
      .rd_addr(rf_ra), .rd_data(rf_rd)
   );

   rv64_exu_muldiv u_md (
      .clock(clock), .reset(reset), .start(md_start), .cmd(md_cmd),
      .a(a_ff), .b(b_ff), .done(md_done), .result(md_result)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = out_ff;

   // registers never written read zero, tracked by a per-entry flag
   always_comb begin
      w   = req_ff.instr_word;
      opc = w[6:0];
      f3  = w[14:12];
      f7  = w[31:25];
      rd  = w[11:7];
      immi = {{52{w[31]}}, w[31:20]};
      imms = {{52{w[31]}}, w[31:25], w[11:7]};
      immb = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      immu = {{32{w[31]}}, w[31:12], 12'd0};
      pc4  = req_ff.instr_pc + 64'd4;
      av   = a_ff;
      bv   = b_ff;
      a32  = {32'd0, av[31:0]};
      wr = 1'b0; unk = 1'b0; tkn = 1'b0; is_md = 1'b0; v = '0; tgt = pc4;
      sh = '0; op2 = '0; lz = 1'b0;
      md_cmd.op = f3;
      md_cmd.word = (opc == OPC_OPW);
      out_in = '0;
      out_in.next_pc = pc4;
      unique case (opc)
         OPC_LOAD: begin
            if (f3 == 3'd7) unk = 1'b1;
            else begin
               out_in.mem_op = MEM_RD_REQ;
               out_in.mem_address = av + immi;
               out_in.mem_bytes = 4'd1 << f3[1:0];
               lz = 1'b1;
            end
         end
         OPC_STORE: begin
            if (f3 > 3'd3) unk = 1'b1;
            else begin
               out_in.mem_op = MEM_WR_REQ;
               out_in.mem_address = av + imms;
               out_in.mem_bytes = 4'd1 << f3[1:0];
               case (f3[1:0])
                  2'd0:    out_in.store_value = {56'd0, bv[7:0]};
                  2'd1:    out_in.store_value = {48'd0, bv[15:0]};
                  2'd2:    out_in.store_value = {32'd0, bv[31:0]};
                  default: out_in.store_value = bv;
               endcase
            end
         end
         OPC_OPIMM, OPC_OP: begin
            wr = 1'b1;
            op2 = (opc == OPC_OP) ? bv : immi;
            sh = op2[5:0];
            if (opc == OPC_OP && f7 == 7'h01) is_md = 1'b1;
            else if (opc == OPC_OP && f7 == 7'h20 && f3 == 3'd0) v = av - bv;
            else if (opc == OPC_OP && f7 == 7'h20 && f3 == 3'd5)
               v = 64'($signed(av) >>> sh);
            else if (opc == OPC_OP && f7 != 7'h00) unk = 1'b1;
            else begin
               case (f3)
                  3'd0: v = av + op2;
                  3'd2: v = {63'd0, $signed(av) < $signed(op2)};
                  3'd3: v = {63'd0, av < op2};
                  3'd4: v = av ^ op2;
                  3'd6: v = av | op2;
                  3'd7: v = av & op2;
                  3'd1: begin
                     if (opc == OPC_OPIMM && w[31:26] != 6'd0) unk = 1'b1;
                     v = av << sh;
                  end
                  default: begin
                     if (opc == OPC_OP || w[31:26] == 6'd0) v = av >> sh;
                     else if (w[31:26] == 6'h10) v = 64'($signed(av) >>> sh);
                     else unk = 1'b1;
                  end
               endcase
            end
         end
         OPC_OPIMMW, OPC_OPW: begin
            wr = 1'b1;
            op2 = (opc == OPC_OPW) ? bv : immi;
            sh = {1'b0, op2[4:0]};
            if (opc == OPC_OPW && f7 == 7'h01 &&
                (f3 == 3'd0 || f3 == 3'd4 || f3 == 3'd5 || f3 == 3'd6 || f3 == 3'd7)) begin
               is_md = 1'b1;
            end else if (f3 == 3'd0 && (opc == OPC_OPIMMW || f7 == 7'h00)) begin
               v = av + op2;
            end else if (opc == OPC_OPW && f3 == 3'd0 && f7 == 7'h20) begin
               v = av - bv;
            end else if (f3 == 3'd1 && f7 == 7'h00) begin
               v = a32 << sh;
            end else if (f3 == 3'd5 && f7 == 7'h00) begin
               v = a32 >> sh;
            end else if (f3 == 3'd5 && f7 == 7'h20) begin
               v = {32'd0, 32'($signed(av[31:0]) >>> sh)};
            end else begin
               unk = 1'b1;
            end
            v = {{32{v[31]}}, v[31:0]};
         end
         OPC_BRANCH: begin
            case (f3)
               3'd0:    tkn = av == bv;
               3'd1:    tkn = av != bv;
               3'd4:    tkn = $signed(av) < $signed(bv);
               3'd5:    tkn = $signed(av) >= $signed(bv);
               3'd6:    tkn = av < bv;
               3'd7:    tkn = av >= bv;
               default: unk = 1'b1;
            endcase
            if (tkn) tgt = req_ff.instr_pc + immb;
         end
         OPC_JAL: begin
            wr = 1'b1; v = pc4; tgt = req_ff.instr_pc + immj;
         end
         OPC_JALR: begin
            if (f3 != 3'd0) unk = 1'b1;
            else begin
               wr = 1'b1; v = pc4; tgt = (av + immi) & ~64'd1;
            end
         end
         OPC_LUI:   begin wr = 1'b1; v = immu; end
         OPC_AUIPC: begin wr = 1'b1; v = req_ff.instr_pc + immu; end
         OPC_SYSTEM: begin
            if (w == INSN_ECALL) out_in.status = ST_ECALL;
            else if (w == INSN_EBREAK) begin
               out_in.status = ST_EBREAK;
               // a0 read data is on the RAM output during execute
               out_in.halt_value = zero_ff[10] ? rf_rd : 64'd0;
            end else unk = 1'b1;
         end
         default: unk = 1'b1;
      endcase
      out_in.next_pc = tgt;
      if (unk) begin
         out_in = '0;
         out_in.next_pc = pc4;
         out_in.status = ST_UNKNOWN;
      end else if (wr && rd != 5'd0) begin
         out_in.reg_write = 1'b1;
         out_in.reg_index = rd;
         out_in.reg_value = v;
      end
   end

   always_comb begin
      unique case (pl_size_ff)
         2'd0:    lmask = 64'h0000_0000_0000_00ff;
         2'd1:    lmask = 64'h0000_0000_0000_ffff;
         2'd2:    lmask = 64'h0000_0000_ffff_ffff;
         default: lmask = '1;
      endcase
      lv = req_data.load_data & lmask;
      if (pl_signed_ff) begin
         unique case (pl_size_ff)
            2'd0:    lv = {{56{lv[7]}}, lv[7:0]};
            2'd1:    lv = {{48{lv[15]}}, lv[15:0]};
            2'd2:    lv = {{32{lv[31]}}, lv[31:0]};
            default: lv = lv;
         endcase
      end
      ld_rsp = '0;
      if (pl_valid_ff && pl_dest_ff != 5'd0) begin
         ld_rsp.reg_write = 1'b1;
         ld_rsp.reg_index = pl_dest_ff;
         ld_rsp.reg_value = lv;
      end
      md_rsp = out_ff;
      md_rsp.reg_value = md_result;
   end

   always_comb begin
      state_in = state_ff;
      pl_valid_in = pl_valid_ff; pl_dest_in = pl_dest_ff;
      pl_size_in = pl_size_ff; pl_signed_in = pl_signed_ff;
      rf_we = 1'b0; rf_wa = '0; rf_wd = '0;
      rf_ra = req_ff.instr_word[19:15];
      md_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            rf_ra = req_data.instr_word[19:15];
            if (req_valid) begin
               if (req_data.action) begin
                  state_in = S_OUT;
                  if (pl_valid_ff) begin
                     pl_valid_in = 1'b0;
                     rf_we = (pl_dest_ff != 5'd0);
                     rf_wa = pl_dest_ff;
                     rf_wd = lv;
                  end
               end else begin
                  state_in = S_RD1;
               end
            end
         end
         S_RD1: begin
            rf_ra = req_ff.instr_word[24:20];
            state_in = S_RD2;
         end
         S_RD2: begin
            rf_ra = 5'd10;
            state_in = S_EXE;
         end
         S_EXE: begin
            if (is_md && !unk) begin
               md_start = 1'b1;
               state_in = S_MD;
            end else begin
               state_in = S_OUT;
               rf_we = out_in.reg_write;
               rf_wa = out_in.reg_index;
               rf_wd = out_in.reg_value;
               if (lz) begin
                  pl_valid_in = 1'b1;
                  pl_dest_in = rd;
                  pl_size_in = f3[1:0];
                  pl_signed_in = ~f3[2];
               end
            end
         end
         S_MD: begin
            if (md_done) begin
               state_in = S_OUT;
               rf_we = (rd != 5'd0);
               rf_wa = rd;
               rf_wd = md_result;
            end
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pl_valid_ff  <= 1'b0;
         pl_dest_ff   <= '0;
         pl_size_ff   <= '0;
         pl_signed_ff <= 1'b0;
         zero_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pl_valid_ff  <= pl_valid_in;
         pl_dest_ff   <= pl_dest_in;
         pl_size_ff   <= pl_size_in;
         pl_signed_ff <= pl_signed_in;
         if (rf_we) zero_ff[rf_wa] <= 1'b1;
      end
      if (state_ff == S_IDLE && req_valid) begin
         req_ff <= req_data;
         if (req_data.action) out_ff <= ld_rsp;
      end
      // read data lands in the cycle after the address
      if (state_ff == S_RD1) a_ff <= zero_ff[req_ff.instr_word[19:15]] ? rf_rd : 64'd0;
      if (state_ff == S_RD2) b_ff <= zero_ff[req_ff.instr_word[24:20]] ? rf_rd : 64'd0;
      if (state_ff == S_EXE) out_ff <= out_in;
      if (state_ff == S_MD && md_done && rd != 5'd0) out_ff <= md_rsp;
   end
endmodule
`default_nettype wire

// ----- tb/tb_rv64im_execute_unit.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_rv64im_execute_unit;
   import rv64_exu_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int unsigned fail_count;
   bit          stim_done;

   rv64im_execute_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      fail_count++;
   endtask

   class exec_scoreboard;
      logic [63:0] regs[32];
      bit          ld_pending;
      logic [4:0]  ld_dest;
      logic [1:0]  ld_size;
      bit          ld_signed;
      rsp_type     expected_q[$];

      function new();
         foreach (regs[i]) regs[i] = '0;
         ld_pending = 0;
         ld_dest = '0;
         ld_size = '0;
         ld_signed = 0;
      endfunction

      function logic [63:0] sext(logic [63:0] v, int bits);
         logic [63:0] m;
         if (bits >= 64) return v;
         m = (64'd1 << bits) - 1;
         v = v & m;
         if (v[bits-1]) v = v | ~m;
         return v;
      endfunction

      function logic [63:0] size_mask(int nb);
         if (nb >= 8) return '1;
         return (64'd1 << (8 * nb)) - 1;
      endfunction

      function logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
         logic [63:0] ua, ub, q;
         if (b == 0) return '1;
         ua = a[63] ? -a : a;
         ub = b[63] ? -b : b;
         q = ua / ub;
         return (a[63] != b[63]) ? -q : q;
      endfunction

      function logic [63:0] srem(logic [63:0] a, logic [63:0] b);
         logic [63:0] ua, ub, r;
         if (b == 0) return a;
         ua = a[63] ? -a : a;
         ub = b[63] ? -b : b;
         r = ua % ub;
         return a[63] ? -r : r;
      endfunction

      function logic [63:0] sra(logic [63:0] a, int sh);
         return $unsigned($signed(a) >>> sh);
      endfunction

      // works out the result of one accepted item and updates the state
      function void note_item(req_type it);
         rsp_type     r;
         logic [31:0] w;
         logic [6:0]  opc, f7;
         logic [2:0]  f3;
         logic [4:0]  rd;
         logic [63:0] a, b, imm_i, v, pc, off, a32, b32;
         logic [127:0] prod;
         bit          wr, unk, t;
         int          nb, sh;
         r = '0;
         v = '0;
         wr = 0;
         unk = 0;
         if (it.action) begin
            if (ld_pending) begin
               nb = 1 << ld_size;
               v = it.load_data & size_mask(nb);
               if (ld_signed) v = sext(v, 8 * nb);
               if (ld_dest != 0) begin
                  regs[ld_dest] = v;
                  r.reg_write = 1;
                  r.reg_index = ld_dest;
                  r.reg_value = v;
               end
               ld_pending = 0;
            end
            expected_q.push_back(r);
            return;
         end
         w = it.instr_word;
         pc = it.instr_pc;
         opc = w[6:0];
         f3 = w[14:12];
         f7 = w[31:25];
         rd = w[11:7];
         a = regs[w[19:15]];
         b = regs[w[24:20]];
         a32 = {32'd0, a[31:0]};
         b32 = {32'd0, b[31:0]};
         imm_i = sext(w[31:20], 12);
         r.next_pc = pc + 4;
         case (opc)
            OPC_LOAD: begin
               if (f3 == 3'd7) unk = 1;
               else begin
                  ld_pending = 1;
                  ld_dest = rd;
                  ld_size = f3[1:0];
                  ld_signed = !f3[2];
                  r.mem_op = MEM_RD_REQ;
                  r.mem_address = a + imm_i;
                  r.mem_bytes = 4'd1 << f3[1:0];
               end
            end
            OPC_STORE: begin
               if (f3 > 3) unk = 1;
               else begin
                  nb = 1 << f3;
                  r.mem_op = MEM_WR_REQ;
                  r.mem_address = a + sext({w[31:25], w[11:7]}, 12);
                  r.mem_bytes = 4'(nb);
                  r.store_value = b & size_mask(nb);
               end
            end
            OPC_OPIMM: begin
               sh = w[25:20];
               wr = 1;
               case (f3)
                  3'd0: v = a + imm_i;
                  3'd2: v = {63'd0, $signed(a) < $signed(imm_i)};
                  3'd3: v = {63'd0, a < imm_i};
                  3'd4: v = a ^ imm_i;
                  3'd6: v = a | imm_i;
                  3'd7: v = a & imm_i;
                  3'd1: if (w[31:26] == 0) v = a << sh; else unk = 1;
                  default: begin
                     if (w[31:26] == 0) v = a >> sh;
                     else if (w[31:26] == 6'h10) v = sra(a, sh);
                     else unk = 1;
                  end
               endcase
            end
            OPC_OPIMMW: begin
               sh = w[24:20];
               wr = 1;
               if (f3 == 0) v = sext(a + imm_i, 32);
               else if (f3 == 1 && f7 == 0) v = sext(a32 << sh, 32);
               else if (f3 == 5 && f7 == 0) v = sext(a32 >> sh, 32);
               else if (f3 == 5 && f7 == 7'h20) v = sra(sext(a32, 32), sh);
               else unk = 1;
            end
            OPC_OP: begin
               wr = 1;
               if (f7 == 0) begin
                  case (f3)
                     3'd0: v = a + b;
                     3'd1: v = a << b[5:0];
                     3'd2: v = {63'd0, $signed(a) < $signed(b)};
                     3'd3: v = {63'd0, a < b};
                     3'd4: v = a ^ b;
                     3'd5: v = a >> b[5:0];
                     3'd6: v = a | b;
                     default: v = a & b;
                  endcase
               end else if (f7 == 7'h20 && f3 == 0) v = a - b;
               else if (f7 == 7'h20 && f3 == 5) v = sra(a, b[5:0]);
               else if (f7 == 1) begin
                  case (f3)
                     MD_MUL: v = a * b;
                     MD_MULH: begin
                        prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
                        v = prod[127:64];
                     end
                     MD_MULHSU: begin
                        prod = {{64{a[63]}}, a} * {64'd0, b};
                        v = prod[127:64];
                     end
                     MD_MULHU: begin
                        prod = {64'd0, a} * {64'd0, b};
                        v = prod[127:64];
                     end
                     MD_DIV:  v = sdiv(a, b);
                     MD_DIVU: v = (b == 0) ? '1 : a / b;
                     MD_REM:  v = srem(a, b);
                     default: v = (b == 0) ? a : a % b;
                  endcase
               end else unk = 1;
            end
            OPC_OPW: begin
               sh = b[4:0];
               wr = 1;
               if (f7 == 0 && f3 == 0) v = sext(a + b, 32);
               else if (f7 == 7'h20 && f3 == 0) v = sext(a - b, 32);
               else if (f7 == 0 && f3 == 1) v = sext(a32 << sh, 32);
               else if (f7 == 0 && f3 == 5) v = sext(a32 >> sh, 32);
               else if (f7 == 7'h20 && f3 == 5) v = sra(sext(a32, 32), sh);
               else if (f7 == 1 && f3 == MD_MUL) v = sext(a32 * b32, 32);
               else if (f7 == 1 && f3 == MD_DIV)
                  v = sext(sdiv(sext(a32, 32), sext(b32, 32)), 32);
               else if (f7 == 1 && f3 == MD_DIVU)
                  v = (b32 == 0) ? '1 : sext(a32 / b32, 32);
               else if (f7 == 1 && f3 == MD_REM)
                  v = sext(srem(sext(a32, 32), sext(b32, 32)), 32);
               else if (f7 == 1 && f3 == MD_REMU)
                  v = sext((b32 == 0) ? a32 : a32 % b32, 32);
               else unk = 1;
            end
            OPC_BRANCH: begin
               off = sext({w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
               case (f3)
                  3'd0: t = a == b;
                  3'd1: t = a != b;
                  3'd4: t = $signed(a) < $signed(b);
                  3'd5: t = $signed(a) >= $signed(b);
                  3'd6: t = a < b;
                  3'd7: t = a >= b;
                  default: begin
                     t = 0;
                     unk = 1;
                  end
               endcase
               if (t) r.next_pc = pc + off;
            end
            OPC_JAL: begin
               wr = 1;
               v = pc + 4;
               r.next_pc = pc + sext({w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
            end
            OPC_JALR: begin
               if (f3 != 0) unk = 1;
               else begin
                  wr = 1;
                  v = pc + 4;
                  r.next_pc = (a + imm_i) & ~64'd1;
               end
            end
            OPC_LUI: begin
               wr = 1;
               v = sext({w[31:12], 12'd0}, 32);
            end
            OPC_AUIPC: begin
               wr = 1;
               v = pc + sext({w[31:12], 12'd0}, 32);
            end
            OPC_SYSTEM: begin
               if (w == INSN_ECALL) r.status = ST_ECALL;
               else if (w == INSN_EBREAK) begin
                  r.status = ST_EBREAK;
                  r.halt_value = regs[10];
               end else unk = 1;
            end
            default: unk = 1;
         endcase
         if (unk) begin
            r.next_pc = pc + 4;
            r.status = ST_UNKNOWN;
         end else if (wr && rd != 0) begin
            regs[rd] = v;
            r.reg_write = 1;
            r.reg_index = rd;
            r.reg_value = v;
         end
         regs[0] = '0;
         expected_q.push_back(r);
      endfunction

      task check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result item", '0, '0);
            return;
         end
         e = expected_q.pop_front();
         if (got.next_pc !== e.next_pc) report_mismatch("next_pc", got.next_pc, e.next_pc);
         if (got.mem_op !== e.mem_op)
            report_mismatch("mem_op", 64'(got.mem_op), 64'(e.mem_op));
         if (got.mem_address !== e.mem_address)
            report_mismatch("mem_address", got.mem_address, e.mem_address);
         if (got.mem_bytes !== e.mem_bytes)
            report_mismatch("mem_bytes", 64'(got.mem_bytes), 64'(e.mem_bytes));
         if (got.store_value !== e.store_value)
            report_mismatch("store_value", got.store_value, e.store_value);
         if (got.reg_write !== e.reg_write)
            report_mismatch("reg_write", 64'(got.reg_write), 64'(e.reg_write));
         if (got.reg_index !== e.reg_index)
            report_mismatch("reg_index", 64'(got.reg_index), 64'(e.reg_index));
         if (got.reg_value !== e.reg_value)
            report_mismatch("reg_value", got.reg_value, e.reg_value);
         if (got.status !== e.status)
            report_mismatch("status", 64'(got.status), 64'(e.status));
         if (got.halt_value !== e.halt_value)
            report_mismatch("halt_value", got.halt_value, e.halt_value);
      endtask
   endclass

   exec_scoreboard sb;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("tb_rv64im_execute_unit NOT OK");
      $finish;
   end

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // accept and check results, stalling at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         rsp_stall <= ($urandom_range(0, 99) < 30);
      end
   end

   // valid stays high into the next item when there is no gap
   task automatic send_item(input req_type it);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(it);
   endtask

   task automatic send_exec(input logic [31:0] w);
      req_type it;
      it.action = 1'b0;
      it.instr_word = w;
      it.instr_pc = {$urandom, $urandom};
      it.load_data = {$urandom, $urandom};
      send_item(it);
   endtask

   task automatic send_load_data(input logic [63:0] d);
      req_type it;
      it.action = 1'b1;
      it.instr_word = $urandom;
      it.instr_pc = {$urandom, $urandom};
      it.load_data = d;
      send_item(it);
   endtask

   function automatic logic [31:0] r_type(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
      return {f7, rs2, rs1, f3, rd, opc};
   endfunction

   // registers for operands drawn from a small set so values get reused
   function automatic logic [4:0] pick_reg();
      return ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, 7));
   endfunction

   // random but mostly legal instruction
   function automatic logic [31:0] random_insn();
      logic [31:0] w;
      logic [6:0]  f7;
      logic [2:0]  f3;
      int          k;
      w = $urandom;
      f3 = 3'($urandom_range(0, 7));
      k = $urandom_range(0, 99);
      if (k < 8) return w;
      if (k < 14) return {w[31:12], pick_reg(), OPC_LUI};
      if (k < 24) return {w[31:20], pick_reg(), f3, pick_reg(), OPC_OPIMM};
      if (k < 30) return {w[31:20], pick_reg(), f3, pick_reg(), OPC_OPIMMW};
      if (k < 45) begin
         f7 = ($urandom_range(0, 2) == 0) ? 7'h20 : (($urandom_range(0, 1) != 0) ? 7'h01 : 7'h00);
         return r_type(f7, pick_reg(), pick_reg(), f3, pick_reg(), OPC_OP);
      end
      if (k < 55) begin
         f7 = ($urandom_range(0, 2) == 0) ? 7'h20 : (($urandom_range(0, 1) != 0) ? 7'h01 : 7'h00);
         return r_type(f7, pick_reg(), pick_reg(), f3, pick_reg(), OPC_OPW);
      end
      if (k < 62) return {w[31:25], pick_reg(), pick_reg(), f3, w[11:7], OPC_BRANCH};
      if (k < 66) return {w[31:12], pick_reg(), OPC_JAL};
      if (k < 70) return {w[31:20], pick_reg(), 3'd0, pick_reg(), OPC_JALR};
      if (k < 74) return {w[31:12], pick_reg(), OPC_AUIPC};
      if (k < 82) return {w[31:25], pick_reg(), pick_reg(), 1'b0, f3[1:0], w[11:7], OPC_STORE};
      if (k < 94) return {w[31:20], pick_reg(), f3, pick_reg(), OPC_LOAD};
      if (k < 96) return INSN_EBREAK;
      if (k < 98) return INSN_ECALL;
      return {w[31:7], OPC_SYSTEM};
   endfunction

   function automatic logic [63:0] random_data();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h0000_0000_8000_0000;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      logic [31:0] w;
      sb = new();
      fail_count = 0;
      stim_done = 0;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: load extreme values, divide corners, x0 write, system codes
      send_exec({12'h000, 5'd0, 3'd3, 5'd1, OPC_LOAD});
      send_load_data(64'h8000_0000_0000_0000);
      send_exec({12'hfff, 5'd0, 3'd0, 5'd2, OPC_OPIMM});
      send_exec(r_type(7'h01, 5'd2, 5'd1, MD_DIV, 5'd3, OPC_OP));
      send_exec(r_type(7'h01, 5'd2, 5'd1, MD_REM, 5'd4, OPC_OP));
      send_exec(r_type(7'h01, 5'd0, 5'd1, MD_DIVU, 5'd5, OPC_OP));
      send_exec(r_type(7'h01, 5'd0, 5'd1, MD_REMU, 5'd6, OPC_OP));
      send_exec(r_type(7'h01, 5'd0, 5'd2, MD_DIVU, 5'd7, OPC_OPW));
      send_exec(r_type(7'h01, 5'd2, 5'd2, MD_MULH, 5'd10, OPC_OP));
      send_exec(r_type(7'h01, 5'd2, 5'd1, MD_MULHSU, 5'd0, OPC_OP));
      send_exec({20'h80000, 5'd9, OPC_LUI});
      send_exec(r_type(7'h01, 5'd2, 5'd9, MD_DIV, 5'd8, OPC_OPW));
      send_exec(INSN_EBREAK);
      send_exec(INSN_ECALL);
      send_exec(32'h0000_000f);
      send_exec(32'hffff_ffff);
      send_load_data('1);
      send_exec({12'h000, 5'd0, 3'd0, 5'd11, OPC_LOAD});
      send_exec({12'h004, 5'd0, 3'd4, 5'd12, OPC_LOAD});
      send_load_data('1);
      send_exec({12'h001, 5'd1, 3'd0, 5'd0, OPC_JALR});
      send_exec({7'h7f, 5'd2, 5'd1, 3'd7, 5'h1f, OPC_STORE});
      send_exec({7'h3f, 5'd2, 5'd0, 3'd1, 5'h1f, OPC_BRANCH});

      repeat (460) begin
         w = random_insn();
         send_exec(w);
         // follow most loads with their data return
         if (w[6:0] == OPC_LOAD && w[14:12] != 3'd7 && $urandom_range(0, 9) != 0)
            send_load_data(random_data());
         else if ($urandom_range(0, 19) == 0)
            send_load_data(random_data());
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_rv64im_execute_unit OK");
      end else begin
         $display("tb_rv64im_execute_unit NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
